>>> rtl/overwrite_ring_sample_logger_macros.svh
// ----------------------------------------------------------------------------
// overwrite ring sample logger assertion macros
// clocked assertion forms shared by the checker
// ----------------------------------------------------------------------------
`ifndef OVERWRITE_RING_SAMPLE_LOGGER_MACROS_SVH
`define OVERWRITE_RING_SAMPLE_LOGGER_MACROS_SVH

// assertion that is off while reset is high
`define ORSL_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("orsl check failed");

// assertion that also looks at reset itself
`define ORSL_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("orsl check failed");

`endif

>>> rtl/orsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orsl_pkg
// shared types, constants and helpers of the sample logger
// ----------------------------------------------------------------------------
package orsl_pkg;

  localparam int DEPTH    = 64;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAPW     = 7;
  localparam int RDW      = 19;
  localparam int TW       = 64;
  localparam int CNTW     = 32;
  localparam int MEMW     = RDW + TW;
  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);
  localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_SNAP   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_DROP   = 2'd1,
    OP_SNAP   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_SNAP   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DROPPED = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_SNAP
  } back_state_t;

  typedef struct packed {
    op_t                   op;
    logic signed [RDW-1:0] reading;
    logic [TW-1:0]         stamp;
    logic [CAPW-1:0]       limit;
  } cmd_t;

  typedef struct packed {
    kind_t                 kind;
    status_t               status;
    logic signed [RDW-1:0] entry_reading;
    logic [TW-1:0]         entry_time;
    logic                  last;
    logic [CAPW-1:0]       fill;
    logic [CNTW-1:0]       total;
    logic [CNTW-1:0]       dropped;
  } res_t;

  // zero acts as one, anything above the built depth acts as the depth
  function automatic logic [CAPW-1:0] cap_clamp(input logic [CAPW-1:0] c);
    logic [CAPW-1:0] r;
    if (c == '0) begin
      r = CAPW'(1);
    end else if (c > CAPW'(DEPTH)) begin
      r = CAPW'(DEPTH);
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

>>> rtl/orsl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orsl_front
// accepts items, classifies them and queues commands for the back end
// ----------------------------------------------------------------------------
module orsl_front import orsl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            mode,
  input  logic                  reading_ok,
  input  logic signed [RDW-1:0] reading_milli,
  input  logic [TW-1:0]         sample_time,
  input  logic [CAPW-1:0]       snapshot_limit,
  input  logic                  cq_pop,
  output logic                  cq_valid,
  output cmd_t                  cq_head
);

  cmd_t             slot [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr;
  logic [CQ_AW-1:0] rd_ptr;
  logic [CQ_CW-1:0] count;
  cmd_t             cmd;
  logic             is_cmd;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    cmd.reading = reading_milli;
    cmd.stamp   = sample_time;
    cmd.limit   = (snapshot_limit > CAPW'(DEPTH)) ? CAPW'(DEPTH) : snapshot_limit;
    is_cmd      = 1'b1;
    case (mode_t'(mode))
      MODE_SAMPLE: cmd.op = reading_ok ? OP_SAMPLE : OP_DROP;
      MODE_SNAP:   cmd.op = OP_SNAP;
      MODE_CLEAR:  cmd.op = OP_CLEAR;
      default: begin
        // unused mode, swallowed without a trace
        cmd.op = OP_CLEAR;
        is_cmd = 1'b0;
      end
    endcase
  end

  assign full     = (count == CQ_CW'(CQ_DEPTH));
  assign cq_valid = (count != '0);
  assign cq_head  = slot[rd_ptr];
  assign do_push  = push && !full && is_cmd;
  assign do_pop   = cq_pop && cq_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/orsl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orsl_back
// ring state, entry memory and the snapshot sequencer
// ----------------------------------------------------------------------------
module orsl_back import orsl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CAPW-1:0]  cap_raw,
  input  logic             cq_valid,
  input  cmd_t             cq_head,
  output logic             cq_pop,
  input  logic [RQ_CW-1:0] rq_count,
  output logic             rq_push,
  output res_t             rq_data
);

  logic [MEMW-1:0] ring_mem [DEPTH];

  back_state_t     state;
  back_state_t     state_next;
  logic [AW-1:0]   wp;
  logic [AW-1:0]   wp_next;
  logic [CAPW-1:0] vc;
  logic [CAPW-1:0] vc_next;
  logic [CNTW-1:0] total;
  logic [CNTW-1:0] total_next;
  logic [CNTW-1:0] dropped;
  logic [CNTW-1:0] dropped_next;
  logic [AW-1:0]   snap_idx;
  logic [AW-1:0]   snap_idx_next;
  logic [CAPW-1:0] snap_left;
  logic [CAPW-1:0] snap_left_next;

  logic            s1_valid;
  res_t            s1_res;
  logic            s1_mem;
  logic [MEMW-1:0] rd_data;

  logic [CAPW-1:0] cap;
  logic [CAPW-1:0] vc_eff;
  logic [AW-1:0]   wp_eff;
  logic [CAPW-1:0] n;
  logic [CAPW:0]   start_sum;
  logic [CAPW:0]   start_mod;
  logic            credit;
  logic            issue;
  logic            iss_mem;
  res_t            iss_res;
  logic            wr_en;
  logic            rd_en;

  always_comb begin
    cap    = cap_clamp(cap_raw);
    vc_eff = (vc > cap) ? cap : vc;
    wp_eff = (CAPW'(wp) >= cap) ? '0 : wp;
    n      = (vc_eff < cq_head.limit) ? vc_eff : cq_head.limit;
    // oldest entry, sum stays below twice the capacity
    start_sum = (CAPW+1)'(wp_eff) + (CAPW+1)'(cap) - (CAPW+1)'(vc_eff);
    start_mod = (start_sum >= (CAPW+1)'(cap)) ? start_sum - (CAPW+1)'(cap) : start_sum;
    // room for this result and the one still in flight
    credit = ((RQ_CW+1)'(rq_count) + (RQ_CW+1)'(s1_valid)) < (RQ_CW+1)'(RQ_DEPTH);

    state_next     = state;
    wp_next        = wp;
    vc_next        = vc;
    total_next     = total;
    dropped_next   = dropped;
    snap_idx_next  = snap_idx;
    snap_left_next = snap_left;
    cq_pop         = 1'b0;
    issue          = 1'b0;
    iss_mem        = 1'b0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    iss_res        = '0;

    case (state)
      BK_IDLE: begin
        if (cq_valid && credit) begin
          cq_pop  = 1'b1;
          wp_next = wp_eff;
          vc_next = vc_eff;
          issue   = 1'b1;
          case (cq_head.op)
            OP_SAMPLE: begin
              wr_en      = 1'b1;
              wp_next    = (CAPW'(wp_eff) + 1'b1 == cap) ? '0 : wp_eff + 1'b1;
              vc_next    = (vc_eff < cap) ? vc_eff + 1'b1 : vc_eff;
              total_next = total + 1'b1;
              iss_res.kind   = KIND_SAMPLE;
              iss_res.status = ST_OK;
            end
            OP_DROP: begin
              dropped_next   = dropped + 1'b1;
              iss_res.kind   = KIND_SAMPLE;
              iss_res.status = ST_DROPPED;
            end
            OP_CLEAR: begin
              wp_next        = '0;
              vc_next        = '0;
              iss_res.kind   = KIND_CLEAR;
              iss_res.status = ST_OK;
            end
            OP_SNAP: begin
              iss_res.kind = KIND_SNAP;
              if (n == '0) begin
                iss_res.status = ST_EMPTY;
              end else begin
                // entries follow from the sequencer
                issue          = 1'b0;
                state_next     = BK_SNAP;
                snap_left_next = n;
                snap_idx_next  = start_mod[AW-1:0];
              end
            end
            default: begin
              issue = 1'b0;
            end
          endcase
          iss_res.last    = 1'b1;
          iss_res.fill    = vc_next;
          iss_res.total   = total_next;
          iss_res.dropped = dropped_next;
        end
      end
      BK_SNAP: begin
        if (credit) begin
          rd_en           = 1'b1;
          issue           = 1'b1;
          iss_mem         = 1'b1;
          iss_res.kind    = KIND_SNAP;
          iss_res.status  = ST_OK;
          iss_res.last    = (snap_left == CAPW'(1));
          iss_res.fill    = vc;
          iss_res.total   = total;
          iss_res.dropped = dropped;
          snap_left_next  = snap_left - 1'b1;
          snap_idx_next   = (CAPW'(snap_idx) + 1'b1 == cap) ? '0 : snap_idx + 1'b1;
          if (snap_left == CAPW'(1)) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      vc        <= '0;
      total     <= '0;
      dropped   <= '0;
      snap_idx  <= '0;
      snap_left <= '0;
      s1_valid  <= 1'b0;
    end else begin
      wp        <= wp_next;
      vc        <= vc_next;
      total     <= total_next;
      dropped   <= dropped_next;
      snap_idx  <= snap_idx_next;
      snap_left <= snap_left_next;
      s1_valid  <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_res <= iss_res;
      s1_mem <= iss_mem;
    end
  end

  // ring memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wp_eff] <= {cq_head.reading, cq_head.stamp};
    end
    if (rd_en) begin
      rd_data <= ring_mem[snap_idx];
    end
  end

  always_comb begin
    rq_push = s1_valid;
    rq_data = s1_res;
    if (s1_mem) begin
      rq_data.entry_reading = rd_data[MEMW-1:TW];
      rq_data.entry_time    = rd_data[TW-1:0];
    end
  end

endmodule

>>> rtl/orsl_resq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orsl_resq
// result queue between the back end and the output ports
// ----------------------------------------------------------------------------
module orsl_resq import orsl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             rq_push,
  input  res_t             rq_data,
  input  logic             pop,
  output logic             empty,
  output res_t             head,
  output logic [RQ_CW-1:0] rq_count
);

  res_t             slot [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr;
  logic [RQ_AW-1:0] rd_ptr;
  logic             do_pop;

  assign empty  = (rq_count == '0);
  assign head   = slot[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rq_push) begin
      slot[wr_ptr] <= rq_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      rq_count <= '0;
    end else begin
      if (rq_push) begin
        wr_ptr <= (wr_ptr == RQ_AW'(RQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == RQ_AW'(RQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({rq_push, do_pop})
        2'b10:   rq_count <= rq_count + 1'b1;
        2'b01:   rq_count <= rq_count - 1'b1;
        default: rq_count <= rq_count;
      endcase
    end
  end

endmodule

>>> rtl/overwrite_ring_sample_logger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_ring_sample_logger
// timestamped temperature history ring that overwrites its oldest entry
// ----------------------------------------------------------------------------
// usage
//   input queue: drive mode and the item fields, raise push; an item is taken
//   at a clock edge with push high and full low. mode 3 items are taken and
//   dropped without a result
//   result queue: while empty is low the oldest result sits on the result
//   ports; raise pop to take it
//   capacity: capacity_we loads capacity_in_use; write it only while idle and
//   clear the ring after changing it
// timing
//   a sample, dropped sample or clear goes through the command queue, the
//   back end result register and the result queue; while the result queue
//   has room the back end takes one such item per cycle, and a snapshot sets
//   up its walk, then streams one entry per cycle from the single read port
// reset
//   rst clears the ring pointer, fill count, both totals and both queues;
//   capacity returns to the built depth, the ring contents are not cleared
// stall
//   when pop stays low the result queue fills, the back end waits, the
//   command queue fills and full rises; nothing is lost
// ----------------------------------------------------------------------------
module overwrite_ring_sample_logger import orsl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  capacity_we,
  input  logic [CAPW-1:0]       capacity_in_use,
  // input queue side
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            mode,
  input  logic                  reading_ok,
  input  logic signed [RDW-1:0] reading_milli,
  input  logic [TW-1:0]         sample_time,
  input  logic [CAPW-1:0]       snapshot_limit,
  // result queue side
  input  logic                  pop,
  output logic                  empty,
  output logic [1:0]            kind,
  output logic [1:0]            status,
  output logic signed [RDW-1:0] entry_reading,
  output logic [TW-1:0]         entry_time,
  output logic                  last,
  output logic [CAPW-1:0]       fill_count,
  output logic [CNTW-1:0]       total_samples,
  output logic [CNTW-1:0]       dropped_samples
);

  // capacity register, raw value; clamping happens in the back end
  logic [CAPW-1:0]  capacity;

  // command queue between front and back
  logic             cq_valid;
  logic             cq_pop;
  cmd_t             cq_head;

  // result queue feed
  logic             rq_push;
  res_t             rq_data;
  logic [RQ_CW-1:0] rq_count;
  res_t             head;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPW'(DEPTH);
    end else if (capacity_we) begin
      capacity <= capacity_in_use;
    end
  end

  // front: accept and classify items
  orsl_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .mode           (mode),
    .reading_ok     (reading_ok),
    .reading_milli  (reading_milli),
    .sample_time    (sample_time),
    .snapshot_limit (snapshot_limit),
    .cq_pop         (cq_pop),
    .cq_valid       (cq_valid),
    .cq_head        (cq_head)
  );

  // back: ring state, memory and snapshot walk
  orsl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cap_raw  (capacity),
    .cq_valid (cq_valid),
    .cq_head  (cq_head),
    .cq_pop   (cq_pop),
    .rq_count (rq_count),
    .rq_push  (rq_push),
    .rq_data  (rq_data)
  );

  // output side queue, parts the back end from the receiver
  orsl_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .rq_push  (rq_push),
    .rq_data  (rq_data),
    .pop      (pop),
    .empty    (empty),
    .head     (head),
    .rq_count (rq_count)
  );

  // result fields straight from the queue head
  assign kind            = head.kind;
  assign status          = head.status;
  assign entry_reading   = head.entry_reading;
  assign entry_time      = head.entry_time;
  assign last            = head.last;
  assign fill_count      = head.fill;
  assign total_samples   = head.total;
  assign dropped_samples = head.dropped;

endmodule

>>> rtl/orsl_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orsl_chk
// port level checks of the sample logger result side
// ----------------------------------------------------------------------------
`include "overwrite_ring_sample_logger_macros.svh"

module orsl_chk import orsl_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  pop,
  input logic                  empty,
  input logic [1:0]            kind,
  input logic [1:0]            status,
  input logic signed [RDW-1:0] entry_reading,
  input logic [TW-1:0]         entry_time,
  input logic                  last,
  input logic [CAPW-1:0]       fill_count
);

  // nothing to show right after reset
  `ORSL_ASSERT_NR(a_empty_after_rst, clk, $past(rst) |-> empty)

  // a waiting result holds until taken
  `ORSL_ASSERT(a_hold, clk, rst, !empty && !pop |=> !empty && $stable(kind) && $stable(entry_time))

  // a clear acknowledge shows an empty ring
  `ORSL_ASSERT(a_clear_ack, clk, rst, !empty && kind == KIND_CLEAR |-> fill_count == '0 && last && status == ST_OK)

  // acknowledges carry no entry and end their item
  `ORSL_ASSERT(a_ack_zero, clk, rst, !empty && kind != KIND_SNAP |-> entry_time == '0 && entry_reading == '0 && last)

endmodule

bind overwrite_ring_sample_logger orsl_chk u_chk (.*);
